// ===== hw/rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants
// Widths, opcodes and the control bundle used by the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W           = 32;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Per-request decision from the tag array
    typedef struct packed {
        logic hit;      // key present
        logic data_we;  // write value store at slot
        logic data_re;  // read value store at slot
    } lkvc_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkvc_if.sv =====
// ----------------------------------------------------------------------------
// lkvc_if: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [lkvc_pkg::KEY_W-1:0]  key;
    logic signed [lkvc_pkg::DATA_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic signed [lkvc_pkg::DATA_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key-value cache, LRU replacement
// A get beat is registered in the input stage, then its answer in the result stage.
// Throughput: 1 beat per cycle unless a get waits on a held response; the tag compare
// and rank update take one pass. A put beat takes the same path and gives no response.
// Reset: asynchronous, active low; all entries invalid, capacity 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
    lkvc_req_if.sink                        req,
    lkvc_rsp_if.source                      rsp
);

    localparam int IW = $clog2(ENTRIES);

    // Capacity register; the user must write it only while idle, the block does not enforce this.
    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

    // Input stage: one request beat.
    logic                        s1_valid_reg;
    logic                        s1_op_reg;
    logic [lkvc_pkg::KEY_W-1:0]  s1_key_reg;
    logic [lkvc_pkg::DATA_W-1:0] s1_value_reg;

    // Result stage: found flag here, value in the RAM's read register.
    logic out_valid_reg;
    logic out_valid_next;
    logic found_reg;

    logic                        s1_adv;
    logic                        s1_is_get;
    lkvc_pkg::lkvc_ctrl_t        ctrl;
    logic [IW-1:0]               slot;
    logic [lkvc_pkg::DATA_W-1:0] ram_rdata;

    // A put never needs the result slot; a get moves when the slot is free
    // or being emptied this cycle.
    assign s1_is_get = (s1_op_reg == lkvc_pkg::OP_GET);
    assign s1_adv    = s1_valid_reg && (!s1_is_get || !out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_op_reg    <= req.opcode;
            s1_key_reg   <= req.key;
            s1_value_reg <= req.value;
        end
    end

    lkvc_tag_array #(
        .ENTRIES (ENTRIES)
    ) u_tag (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .fire     (s1_adv),
        .opcode   (s1_op_reg),
        .key      (s1_key_reg),
        .ctrl     (ctrl),
        .slot     (slot)
    );

    // Value store; read data register doubles as the result value register.
    lkvc_ram #(
        .WIDTH (lkvc_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_data (
        .clk   (clk),
        .we    (s1_adv && ctrl.data_we),
        .waddr (slot),
        .wdata (s1_value_reg),
        .re    (s1_adv && ctrl.data_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (s1_adv && s1_is_get)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_is_get)
        begin
            found_reg <= ctrl.hit;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = found_reg ? ram_rdata : lkvc_pkg::MISS_VALUE;

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_ram.sv =====
// ----------------------------------------------------------------------------
// lkvc_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_tag_array.sv =====
// ----------------------------------------------------------------------------
// lkvc_tag_array: keys, valid bits, recency ranks and fill count
// Parallel key compare and slot choice are combinational; the rank update is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_tag_array #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [lkvc_pkg::CAP_W-1:0]       capacity,
    input  wire logic                             fire,
    input  wire logic                             opcode,
    input  wire logic [lkvc_pkg::KEY_W-1:0]       key,
    output lkvc_pkg::lkvc_ctrl_t                  ctrl,
    output logic      [$clog2(ENTRIES)-1:0]       slot
);

    localparam int IW = $clog2(ENTRIES);
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > lkvc_pkg::CAP_W) ? UW : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::KEY_W-1:0] key_reg   [ENTRIES];
    logic                       valid_reg [ENTRIES];
    logic [IW-1:0]              rank_reg  [ENTRIES];
    logic [UW-1:0]              used_reg;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] lru_vec;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      lru_idx;
    logic [IW-1:0]      hit_rank;
    logic [UW-1:0]      used_m1;
    logic [CW-1:0]      eff_cap;
    logic               hit;
    logic               fresh;
    logic               is_put;
    logic [UW-1:0]      thresh;

    // Ranks of valid entries always form 0..used-1, and slots fill from 0 up,
    // so the least recent entry has rank used-1 and the free slot is used.
    always_comb
    begin
        used_m1  = used_reg - UW'(1);
        hit_idx  = '0;
        lru_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == key);
            lru_vec[i] = valid_reg[i] && (UW'(rank_reg[i]) == used_m1);
            if (hit_vec[i])
            begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (lru_vec[i])
            begin
                lru_idx = lru_idx | IW'(i);
            end
        end
    end

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(capacity) > CW'(ENTRIES))
        begin
            eff_cap = CW'(ENTRIES);
        end
        else
        begin
            eff_cap = CW'(capacity);
        end
    end

    assign hit    = |hit_vec;
    assign is_put = (opcode == lkvc_pkg::OP_PUT);
    assign fresh  = (CW'(used_reg) < eff_cap);

    always_comb
    begin
        if (hit)
        begin
            slot   = hit_idx;
            thresh = UW'(hit_rank);
        end
        else if (fresh)
        begin
            slot   = used_reg[IW-1:0];
            thresh = used_reg;
        end
        else
        begin
            slot   = lru_idx;
            thresh = used_m1;
        end
    end

    assign ctrl.hit     = hit;
    assign ctrl.data_we = is_put;
    assign ctrl.data_re = !is_put && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
            used_reg <= '0;
        end
        else if (fire && (hit || is_put))
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IW'(i) == slot)
                begin
                    valid_reg[i] <= 1'b1;
                    rank_reg[i]  <= '0;
                end
                else if (valid_reg[i] && (UW'(rank_reg[i]) < thresh))
                begin
                    rank_reg[i] <= rank_reg[i] + IW'(1);
                end
            end
            if (is_put && !hit && fresh)
            begin
                used_reg <= used_reg + UW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_put && !hit)
        begin
            key_reg[slot] <= key;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Sees only the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic                        rsp_found,
    input wire logic [lkvc_pkg::DATA_W-1:0] rsp_read_value
);

    // A miss always reads back all ones.
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_found) |-> (rsp_read_value == lkvc_pkg::MISS_VALUE))
        else $error("miss beat without all-ones value");

    // With the result slot empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty result slot");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(rsp_found) && $stable(rsp_read_value)))
        else $error("response payload changed while stalled");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value)
);

`default_nettype wire

// ===== tb/lkvc_cache_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_cache_checker: response predictor and comparator for the LRU cache
// Watches both channels and the capacity writes, and keeps its own LRU table.
// Each response beat is matched against the oldest predicted get answer.
// ----------------------------------------------------------------------------
module lkvc_cache_checker #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       run_done,
    lkvc_req_if                        req,
    lkvc_rsp_if                        rsp,
    output int unsigned                rsp_count,
    output int unsigned                hit_count,
    output int unsigned                mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int unsigned PRINT_LIMIT = 50;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] read_value;
    } get_answer_t;

    logic [KEY_W-1:0]  slot_key  [ENTRIES];
    logic [DATA_W-1:0] slot_data [ENTRIES];
    logic              slot_live [ENTRIES];
    int unsigned       slot_age  [ENTRIES];
    int unsigned       live_count;
    logic [CAP_W-1:0]  capacity_reg;
    get_answer_t       pending_answers[$];
    bit                leftovers_checked;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    // 0 acts as 1, anything above the table size acts as the table size
    function automatic int unsigned capacity_limit();
        int unsigned c;
        c = capacity_reg;
        if (c < 1)
            c = 1;
        if (c > ENTRIES)
            c = ENTRIES;
        return c;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void make_newest(input int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != s && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic int oldest_slot();
        int v;
        v = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && (v < 0 || slot_age[i] > slot_age[v]))
                v = i;
        return v;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < ENTRIES; i++)
            if (!slot_live[i])
                return i;
        return -1;
    endfunction

    // Updates the table for one request; returns 1 when a get answer is due
    function automatic bit apply_request(input logic op, input logic [KEY_W-1:0] k,
                                         input logic [DATA_W-1:0] v,
                                         output get_answer_t answer);
        int s;
        s = find_slot(k);
        answer.found      = 1'b0;
        answer.read_value = MISS_VALUE;
        if (op == OP_GET) begin
            if (s >= 0) begin
                make_newest(s);
                answer.found      = 1'b1;
                answer.read_value = slot_data[s];
            end
            return 1'b1;
        end
        if (s >= 0) begin
            slot_data[s] = v;
            make_newest(s);
            return 1'b0;
        end
        s = -1;
        if (live_count < capacity_limit())
            s = first_free();
        if (s >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i])
                    slot_age[i]++;
            slot_live[s] = 1'b1;
            slot_age[s]  = 0;
            live_count++;
        end else begin
            // evict the least recent entry and reuse its slot
            s = oldest_slot();
            if (s < 0)
                return 1'b0;
            make_newest(s);
        end
        slot_key[s]  = k;
        slot_data[s] = v;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        get_answer_t answer;
        get_answer_t want;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_key[i]  = '0;
                slot_data[i] = '0;
                slot_live[i] = 1'b0;
                slot_age[i]  = 0;
            end
            live_count        = 0;
            capacity_reg      = CAP_RESET;
            leftovers_checked = 1'b0;
            pending_answers.delete();
            mismatches        = 0;
            rsp_count        <= 0;
            hit_count        <= 0;
        end else begin
            if (cfg_wr_en)
                capacity_reg = cfg_wr_data;
            // responses first: a response never belongs to a get of this cycle
            if (rsp.valid && rsp.ready) begin
                rsp_count <= rsp_count + 1;
                if (pending_answers.size() == 0) begin
                    report_mismatch("response beat with no get pending", rsp.read_value, '0);
                end else begin
                    want = pending_answers.pop_front();
                    if (rsp.found !== want.found)
                        report_mismatch("found", {{(DATA_W-1){1'b0}}, rsp.found},
                                        {{(DATA_W-1){1'b0}}, want.found});
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                end
            end
            if (req.valid && req.ready) begin
                if (apply_request(req.opcode, req.key, req.value, answer)) begin
                    pending_answers.push_back(answer);
                    if (answer.found)
                        hit_count <= hit_count + 1;
                end
            end
            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (pending_answers.size() != 0)
                    report_mismatch("gets left without a response",
                                    DATA_W'(pending_answers.size()), '0);
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the LRU key-value cache
// Drives get and put beats under varying stall mixes and capacity settings;
// prediction and comparison live in lkvc_cache_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    // get -> response passes the input and result stages; a put can still be in flight
    localparam int RSP_LATENCY = 2;
    // cycles without any beat before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    localparam int BLOCK_ITEMS = 50;
    localparam int KEY_POOL    = 24;
    localparam int HOT_PCT     = 85;

    // keys at the corners of the signed and unsigned ranges
    localparam logic [KEY_W-1:0] EDGE_KEYS [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             run_done;

    int unsigned rsp_count;
    int unsigned hit_count;
    int unsigned mismatches;

    int unsigned gets_sent;
    int unsigned beats_sent;
    int unsigned cap_writes;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_cycles = 0;

    logic [KEY_W-1:0] key_pool [KEY_POOL];

    lkvc_req_if req_ch();
    lkvc_rsp_if rsp_ch();

    lru_key_value_cache_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    lkvc_cache_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .run_done    (run_done),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .rsp_count   (rsp_count),
        .hit_count   (hit_count),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready is redrawn every edge from the current stall mix.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any beat on either channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // One request beat. Random gaps before it; valid stays high into the
    // next beat, so back-to-back beats never toggle valid within a step.
    // Sampling right after the edge sees the pre-edge ready, which is the
    // value the handshake used.
    task automatic issue_request(input logic op, input logic [KEY_W-1:0] k,
                                 input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.key    <= k;
        req_ch.value  <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
        if (op == OP_GET)
            gets_sent++;
    endtask

    // Hold the sender off until every get has been answered, then let any
    // trailing put clear the pipe. rsp_count is updated with a nonblocking
    // assignment, which only makes the wait longer.
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (gets_sent != rsp_count)
            @(posedge clk);
        repeat (RSP_LATENCY + 1) @(posedge clk);
    endtask

    // Capacity is only written with the cache idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_writes++;
    endtask

    // A block of random beats under one capacity. Most keys come from a small
    // hot set a little larger than the capacity, so hits, updates and
    // evictions all happen; the rest are fresh random keys.
    task automatic run_block(input logic [CAP_W-1:0] cap, input int unsigned items);
        int unsigned lim;
        int unsigned window;
        logic [KEY_W-1:0] k;
        write_capacity(cap);
        lim = (cap == 0) ? 1 : ((cap > ENTRIES_DEFAULT) ? ENTRIES_DEFAULT : cap);
        window = (lim + 4 > KEY_POOL) ? KEY_POOL : lim + 4;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = ($urandom_range(7) == 0) ? EDGE_KEYS[$urandom_range(3)]
                                                   : KEY_W'($urandom);
        for (int n = 0; n < items; n++)
        begin
            if ($urandom_range(99) < HOT_PCT)
                k = key_pool[$urandom_range(window - 1)];
            else
                k = KEY_W'($urandom);
            issue_request(1'($urandom_range(1)), k, DATA_W'($urandom));
        end
    endtask

    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_GET;
        req_ch.key    = '0;
        req_ch.value  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        run_done      = 1'b0;
        rst_n         = 1'b0;
        gets_sent     = 0;
        beats_sent    = 0;
        cap_writes    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 60;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part, reset capacity of 16 ----------------
        issue_request(OP_GET, 32'h0000_0000, 32'h1234_5678);      // miss on empty table
        issue_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);      // most negative key
        issue_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);      // most positive key
        issue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        issue_request(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue_request(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);      // update in place
        issue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);      // hit whose data is -1
        issue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);      // miss, key -1
        issue_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(OP_GET, 32'hFFFF_FFFF, 32'h5555_5555);

        // Capacity dropped under the live count: next new key evicts one,
        // the least recent (0x7FFFFFFF here).
        write_capacity(5'd2);
        issue_request(OP_PUT, 32'h1234_5678, 32'h0000_0001);
        issue_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        issue_request(OP_GET, 32'h1234_5678, 32'h0000_0000);

        // Capacity zero behaves as one: each new key evicts the least recent entry.
        write_capacity(5'd0);
        issue_request(OP_PUT, 32'h0000_0001, 32'h5555_5555);
        issue_request(OP_PUT, 32'h0000_0002, 32'hAAAA_AAAA);
        issue_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
        issue_request(OP_GET, 32'h0000_0002, 32'h0000_0000);

        // Capacity above the table size behaves as the table size.
        write_capacity(5'd31);
        issue_request(OP_PUT, 32'h0000_0003, 32'h0F0F_0F0F);
        issue_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
        issue_request(OP_GET, 32'h0000_0003, 32'h0000_0000);

        // ---------------- random part ----------------
        // Sender mostly busy, receiver stalling hard.
        send_idle_pct = 11;
        recv_idle_pct = 60;
        run_block(5'd16, BLOCK_ITEMS);
        run_block(5'd1,  BLOCK_ITEMS);                // lowered below a full table
        run_block(5'd5,  BLOCK_ITEMS);

        // Sender gappy, receiver mostly ready.
        send_idle_pct = 60;
        recv_idle_pct = 11;
        run_block(5'd31, BLOCK_ITEMS);
        run_block(5'd0,  BLOCK_ITEMS);
        run_block(5'd3,  BLOCK_ITEMS);

        // Full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_block(5'($urandom_range(16, 1)), BLOCK_ITEMS);
        run_block(5'd16, BLOCK_ITEMS);
        run_block(5'd2,  BLOCK_ITEMS);

        // Drain, give the pipe more edges, then collect leftovers.
        wait_quiet();
        repeat (RSP_LATENCY + 2) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d request beats: %0d gets (%0d hits) across %0d capacity writes",
                 beats_sent, gets_sent, hit_count, cap_writes);
        $display("capacities 0, 1, 2, 16 and 31 seen; stalls on each side, then full rate");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
